// ===== rtl/pcirc_pkg.sv =====
// shared types, constants and widths of the per-core idle residency counter
package pcirc_pkg;

	localparam int NUM_CORES_DEF = 64;
	localparam int REQ_TYPE_W    = 3;
	localparam int CORE_W        = 6;
	localparam int TIME_W        = 40;
	localparam int CNT_W         = 32;
	localparam int PCT_W         = 7;

	localparam logic [REQ_TYPE_W-1:0] REQ_ENTER   = 3'd0;
	localparam logic [REQ_TYPE_W-1:0] REQ_EXIT    = 3'd1;
	localparam logic [REQ_TYPE_W-1:0] REQ_TICK    = 3'd2;
	localparam logic [REQ_TYPE_W-1:0] REQ_STATS   = 3'd3;
	localparam logic [REQ_TYPE_W-1:0] REQ_PERCENT = 3'd4;

	typedef struct packed {
		logic [TIME_W-1:0] enter_time;
		logic [TIME_W-1:0] idle_total;
		logic [CNT_W-1:0]  entry_count;
		logic [TIME_W-1:0] first_time;
		logic [CNT_W-1:0]  tick_count;
		logic              idle_flag;
		logic              seen;
	} pcirc_row_t;

	typedef struct packed {
		logic              ok;
		logic [TIME_W-1:0] idle_ms;
		logic [TIME_W-1:0] since_first_ms;
		logic [CNT_W-1:0]  enter_cnt;
		logic [CNT_W-1:0]  tick_cnt;
		logic [PCT_W-1:0]  idle_percent;
	} pcirc_rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOOK,
		ST_APPLY,
		ST_WALK,
		ST_DRAIN,
		ST_DIVIDE,
		ST_HOLD
	} pcirc_state_t;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		logic [CNT_W-1:0] r;
		r = (v == '1) ? v : v + CNT_W'(1);
		return r;
	endfunction

endpackage

// ===== rtl/pcirc_req_if.sv =====
// request channel: valid/ready with request type, core and time stamp
interface pcirc_req_if import pcirc_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [REQ_TYPE_W-1:0] req_type;
	logic [CORE_W-1:0]     core;
	logic [TIME_W-1:0]     now_ms;

	modport source (output valid, req_type, core, now_ms, input ready);
	modport sink (input valid, req_type, core, now_ms, output ready);
endinterface

// ===== rtl/pcirc_rsp_if.sv =====
// response channel: valid/ready with per-core statistics and idle percentage
interface pcirc_rsp_if import pcirc_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              ok;
	logic [TIME_W-1:0] idle_ms;
	logic [TIME_W-1:0] since_first_ms;
	logic [CNT_W-1:0]  enter_cnt;
	logic [CNT_W-1:0]  tick_cnt;
	logic [PCT_W-1:0]  idle_percent;

	modport source (output valid, ok, idle_ms, since_first_ms, enter_cnt, tick_cnt,
		idle_percent, input ready);
	modport sink (input valid, ok, idle_ms, since_first_ms, enter_cnt, tick_cnt,
		idle_percent, output ready);
endinterface

// ===== rtl/pcirc_store.sv =====
// per-core record memory with registered read and per-entry valid bits
module pcirc_store import pcirc_pkg::*; #(
	parameter int NUM_CORES = NUM_CORES_DEF,
	localparam int AW = (NUM_CORES > 1) ? $clog2(NUM_CORES) : 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [AW-1:0] rd_addr,
	output pcirc_row_t    rd_row,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  pcirc_row_t    wr_row
);

	pcirc_row_t           mem [NUM_CORES];
	logic [NUM_CORES-1:0] valid_q;
	pcirc_row_t           rd_row_q;
	logic                 rd_valid_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_row;
		end
		rd_row_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			rd_valid_q <= valid_q[rd_addr];
		end
	end

	// never-written entries read as cleared records
	assign rd_row = rd_valid_q ? rd_row_q : '0;

endmodule

// ===== rtl/pcirc_stats.sv =====
// live idle time and uptime of one record, then saturating idle total
module pcirc_stats import pcirc_pkg::*; (
	input  logic              clk,
	input  pcirc_row_t        row,
	input  logic [TIME_W-1:0] now_ms,
	output pcirc_row_t        row_s2,
	output logic [TIME_W-1:0] live_s2,
	output logic [TIME_W-1:0] up_s2,
	output logic [TIME_W-1:0] idle
);

	logic [TIME_W:0] idle_sum;

	always_ff @(posedge clk) begin
		row_s2  <= row;
		live_s2 <= (row.idle_flag && (now_ms > row.enter_time)) ?
			now_ms - row.enter_time : '0;
		up_s2   <= (now_ms > row.first_time) ? now_ms - row.first_time : '0;
	end

	assign idle_sum = {1'b0, row_s2.idle_total} + {1'b0, live_s2};
	assign idle     = idle_sum[TIME_W] ? '1 : idle_sum[TIME_W-1:0];

endmodule

// ===== rtl/pcirc_div.sv =====
// idle percentage: cap, scale by one hundred, restoring divide one bit a cycle
module pcirc_div import pcirc_pkg::*; #(
	parameter int NUM_CORES = NUM_CORES_DEF,
	localparam int SUM_W = TIME_W + $clog2(NUM_CORES)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [SUM_W-1:0] isum,
	input  logic [SUM_W-1:0] tsum,
	output logic             done,
	output logic [PCT_W-1:0] pct
);

	localparam int PROD_W = SUM_W + PCT_W;
	localparam int STEP_W = $clog2(PCT_W + 1);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [PROD_W-1:0] num_q;
	logic [PROD_W-1:0] dsh_q;
	logic [PCT_W-1:0]  quo_q;
	logic              zero_q;
	logic              ge;

	assign ge = (num_q >= dsh_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= busy_q && (step_q == STEP_W'(PCT_W));
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + STEP_W'(1);
				if (step_q == STEP_W'(PCT_W)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q  <= PROD_W'((isum > tsum) ? tsum : isum);
			dsh_q  <= PROD_W'(tsum) << (PCT_W - 1);
			zero_q <= (tsum == '0);
			quo_q  <= '0;
		end else if (busy_q) begin
			if (step_q == '0) begin
				// times 100 as 64 + 32 + 4
				num_q <= (num_q << 6) + (num_q << 5) + (num_q << 2);
			end else begin
				if (ge) begin
					num_q <= num_q - dsh_q;
				end
				dsh_q <= dsh_q >> 1;
				quo_q <= {quo_q[PCT_W-2:0], ge};
			end
		end
	end

	assign done = done_q;
	assign pct  = zero_q ? '0 : quo_q;

endmodule

// ===== rtl/per_core_idle_residency_counter.sv =====
// per-core idle residency counter top level: sequencer, walk accumulators, result register
// enter, exit, tick and stats items: the memory read, the live-time stage and the write-back
//   lie between accept and result; the next item is accepted once the result is in the output register.
// percent items: one memory read per core, then a drain of the read pipe and a
//   7-step restoring divide.
// reset clears all records at once through per-entry valid bits; no clearing pass.
// a finished result waits in the output register while the next item is accepted.
module per_core_idle_residency_counter import pcirc_pkg::*; #(
	parameter int NUM_CORES = NUM_CORES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	pcirc_req_if.sink         req,
	pcirc_rsp_if.source       rsp
);

	localparam int AW    = (NUM_CORES > 1) ? $clog2(NUM_CORES) : 1;
	localparam int SUM_W = TIME_W + $clog2(NUM_CORES);

	pcirc_state_t          state_q, state_d;
	logic [REQ_TYPE_W-1:0] req_type_q;
	logic [AW-1:0]         addr_q;
	logic                  in_range_q;
	logic [TIME_W-1:0]     now_q;
	logic [AW:0]           walk_q;
	logic [SUM_W-1:0]      isum_q;
	logic [SUM_W-1:0]      tsum_q;
	logic                  rv_s1;
	logic                  v_s2;
	logic                  v_s3;
	logic [TIME_W-1:0]     idle_s3;
	pcirc_rsp_t            res_q;
	pcirc_rsp_t            out_q;
	logic                  out_v_q;

	logic          accept;
	logic          slot_free;
	logic          walk_last;
	logic          drained;
	logic          produce;
	logic          load_out;
	pcirc_rsp_t    res_d;
	pcirc_rsp_t    out_d;
	logic [AW-1:0] rd_addr;
	logic          wr_en;
	pcirc_row_t    wr_row;
	logic          div_start;
	logic          div_done;
	logic [PCT_W-1:0] div_pct;

	pcirc_row_t        rd_row;
	pcirc_row_t        row_s2;
	logic [TIME_W-1:0] live_s2;
	logic [TIME_W-1:0] up_s2;
	logic [TIME_W-1:0] idle;

	pcirc_store #(.NUM_CORES(NUM_CORES)) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_addr (rd_addr),
		.rd_row  (rd_row),
		.wr_en   (wr_en),
		.wr_addr (addr_q),
		.wr_row  (wr_row)
	);

	pcirc_stats u_stats (
		.clk     (clk),
		.row     (rd_row),
		.now_ms  (now_q),
		.row_s2  (row_s2),
		.live_s2 (live_s2),
		.up_s2   (up_s2),
		.idle    (idle)
	);

	pcirc_div #(.NUM_CORES(NUM_CORES)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.isum   (isum_q),
		.tsum   (tsum_q),
		.done   (div_done),
		.pct    (div_pct)
	);

	assign accept    = req.valid && req.ready;
	assign slot_free = !out_v_q || rsp.ready;
	assign walk_last = (walk_q == (AW + 1)'(NUM_CORES - 1));
	assign drained   = !rv_s1 && !v_s2 && !v_s3;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req.valid) begin
					state_d = (req.req_type == REQ_PERCENT) ? ST_WALK : ST_LOOK;
				end
			end
			ST_LOOK: state_d = ST_APPLY;
			ST_APPLY: state_d = slot_free ? ST_IDLE : ST_HOLD;
			ST_WALK: begin
				if (walk_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (drained) begin
					state_d = ST_DIVIDE;
				end
			end
			ST_DIVIDE: begin
				if (div_done) begin
					state_d = slot_free ? ST_IDLE : ST_HOLD;
				end
			end
			ST_HOLD: begin
				if (slot_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		req.ready = (state_q == ST_IDLE);
		rd_addr   = (state_q == ST_WALK) ? walk_q[AW-1:0] : AW'(req.core);
		div_start = (state_q == ST_DRAIN) && drained;
		wr_en     = 1'b0;
		wr_row    = row_s2;
		res_d     = '0;
		produce   = 1'b0;
		case (state_q)
			ST_APPLY: begin
				produce = 1'b1;
				case (req_type_q)
					REQ_ENTER: begin
						wr_en = in_range_q;
						if (!row_s2.seen) begin
							wr_row.seen       = 1'b1;
							wr_row.first_time = now_q;
						end
						wr_row.enter_time  = now_q;
						wr_row.idle_flag   = 1'b1;
						wr_row.entry_count = sat_inc(row_s2.entry_count);
					end
					REQ_EXIT: begin
						wr_en = in_range_q && row_s2.idle_flag;
						wr_row.idle_total = idle;
						wr_row.idle_flag  = 1'b0;
					end
					REQ_TICK: begin
						wr_en = in_range_q;
						wr_row.tick_count = sat_inc(row_s2.tick_count);
					end
					REQ_STATS: begin
						if (in_range_q && row_s2.seen) begin
							res_d.ok             = 1'b1;
							res_d.idle_ms        = idle;
							res_d.since_first_ms = up_s2;
							res_d.enter_cnt      = row_s2.entry_count;
							res_d.tick_cnt       = row_s2.tick_count;
						end
					end
					default: res_d = '0;
				endcase
			end
			ST_DIVIDE: begin
				produce            = div_done;
				res_d.ok           = 1'b1;
				res_d.idle_percent = div_pct;
			end
			default: produce = 1'b0;
		endcase
		out_d    = (state_q == ST_HOLD) ? res_q : res_d;
		load_out = slot_free && (produce || (state_q == ST_HOLD));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_v_q <= 1'b0;
			rv_s1   <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
		end else begin
			state_q <= state_d;
			rv_s1   <= (state_q == ST_WALK);
			v_s2    <= rv_s1;
			v_s3    <= v_s2 && row_s2.seen;
			if (load_out) begin
				out_v_q <= 1'b1;
			end else if (rsp.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_type_q <= req.req_type;
			addr_q     <= AW'(req.core);
			in_range_q <= (9'(req.core) < 9'(NUM_CORES));
			now_q      <= req.now_ms;
			walk_q     <= '0;
			isum_q     <= '0;
			tsum_q     <= '0;
		end else begin
			if (state_q == ST_WALK) begin
				walk_q <= walk_q + (AW + 1)'(1);
			end
			if (v_s2 && row_s2.seen) begin
				tsum_q <= tsum_q + SUM_W'(up_s2);
			end
			if (v_s3) begin
				isum_q <= isum_q + SUM_W'(idle_s3);
			end
		end
		idle_s3 <= idle;
		if (produce && !slot_free) begin
			res_q <= res_d;
		end
		if (load_out) begin
			out_q <= out_d;
		end
	end

	assign rsp.valid          = out_v_q;
	assign rsp.ok             = out_q.ok;
	assign rsp.idle_ms        = out_q.idle_ms;
	assign rsp.since_first_ms = out_q.since_first_ms;
	assign rsp.enter_cnt      = out_q.enter_cnt;
	assign rsp.tick_cnt       = out_q.tick_cnt;
	assign rsp.idle_percent   = out_q.idle_percent;

endmodule
